// ===== hdl/rpc_pkg.sv =====
package rpc_pkg;

  localparam int BODY_SLOTS = 4;
  localparam int AXES = 3;

  localparam int FIX_SHIFT = 12;
  localparam int DEADBAND_UNITS = 2;
  localparam logic [33:0] DEADBAND_ERR = 34'(DEADBAND_UNITS << FIX_SHIFT);

  localparam logic [6:0] PCT_MIN = 7'd1;
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] PCT_DEN = 7'd100;

  localparam logic [6:0] RESET_LERP_PERCENT = 7'd25;
  localparam logic [15:0] RESET_SNAP_DIST = 16'd60;
  localparam logic [7:0] RESET_LOCAL_SLOT = 8'd0;

  // ceil(2^31 / 100); exact floor(x / 100) for every x below 2^24.
  localparam int RECIP_SHIFT = 31;
  localparam logic [24:0] RECIP_100 = 25'd21474837;

  typedef enum logic [1:0] {
    CFG_LERP_PERCENT = 2'd0,
    CFG_SNAP_DIST    = 2'd1,
    CFG_LOCAL_SLOT   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    OUTCOME_SKIP     = 3'd0,
    OUTCOME_DEADBAND = 3'd1,
    OUTCOME_LERP     = 3'd2,
    OUTCOME_SNAP     = 3'd3,
    OUTCOME_TELEPORT = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [6:0]  pct;
    logic [15:0] snap_dist;
    logic [7:0]  local_slot;
  } cfg_t;

  typedef struct packed {
    logic [7:0]             body_slot;
    logic                   teleport;
    logic [15:0]            target_yaw;
    logic [AXES-1:0][31:0]  target;
    logic                   body_present;
    logic [AXES-1:0][31:0]  current;
  } item_t;

  typedef struct packed {
    logic                   elig;
    logic                   tele;
    logic [15:0]            yaw;
    logic [AXES-1:0][31:0]  target;
    logic [AXES-1:0][31:0]  current;
    logic [AXES-1:0]        neg;
    logic [AXES-1:0][31:0]  mag;
  } diff_t;

  typedef struct packed {
    logic                   elig;
    logic                   tele;
    logic [15:0]            yaw;
    logic [AXES-1:0][31:0]  target;
    logic [AXES-1:0][31:0]  current;
    logic [AXES-1:0]        neg;
    logic [33:0]            err;
    logic [AXES-1:0][22:0]  prod_hi;
    logic [AXES-1:0][22:0]  prod_lo;
  } sum_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [15:0]            yaw;
    logic [AXES-1:0][31:0]  target;
    logic [AXES-1:0][31:0]  current;
    logic [AXES-1:0]        neg;
    logic [33:0]            err;
    logic [33:0]            worst;
    logic [31:0]            applied;
    logic [31:0]            lerps;
    logic [31:0]            snaps;
  } decision_t;

  typedef struct packed {
    logic ld_in;
    logic ld_diff;
    logic ld_sum;
    logic ld_judge;
    logic ld_rem;
    logic ld_quot;
  } pipe_ctl_t;

  function automatic logic [16:0] div100(input logic [23:0] value);
    logic [48:0] prod;
    prod = 49'(value) * 49'(RECIP_100);
    return prod[RECIP_SHIFT+16:RECIP_SHIFT];
  endfunction

endpackage

// ===== hdl/remote_position_correction.sv =====
// Corrects a remote body's position toward an authoritative record. One record
// is taken per clock cycle while in_stall is low, and its result passes through
// the seven register stages: input capture, axis differences, error sum and
// percent products, decision with state update, and the two halves of the
// divide by one hundred followed by the output register. Records for the
// local slot, for a slot at or beyond the body slot count, or for an
// absent body are passed with the current position and outcome "skipped". The
// worst-error value and the three wrapping counters reported with each result
// are the values after that record. A lerp percent of zero behaves as one and
// any value above one hundred behaves as one hundred. Configuration writes are
// always accepted and must only be issued while no record is in flight.
module remote_position_correction
  import rpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         body_slot,
  input  logic               teleport,
  input  logic signed [15:0] target_yaw,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic               body_present,
  input  logic signed [31:0] current_x,
  input  logic signed [31:0] current_y,
  input  logic signed [31:0] current_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_z,
  output logic signed [15:0] new_yaw,
  output logic               write_back,
  output logic [2:0]         outcome,
  output logic [33:0]        error_l1,
  output logic [33:0]        worst_error_seen,
  output logic [31:0]        applied_total,
  output logic [31:0]        lerp_total,
  output logic [31:0]        snap_total
);

  localparam int STAGES = 7;

  cfg_t                  cfg;
  item_t                 item;
  sum_t                  sum;
  decision_t             dec;
  pipe_ctl_t             ctl;
  logic [AXES-1:0][32:0] quot;
  logic [STAGES:1]       stage_valid;
  logic [STAGES:1]       free;
  logic                  ld_out;
  logic [AXES-1:0][31:0] pos_next;

  always_comb begin
    item.body_slot    = body_slot;
    item.teleport     = teleport;
    item.target_yaw   = target_yaw;
    item.target[0]    = target_x;
    item.target[1]    = target_y;
    item.target[2]    = target_z;
    item.body_present = body_present;
    item.current[0]   = current_x;
    item.current[1]   = current_y;
    item.current[2]   = current_z;
  end

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    free[STAGES] = !stage_valid[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      free[k] = !stage_valid[k] || free[k+1];
    end
  end

  always_comb begin
    ctl.ld_in    = in_valid && free[1];
    ctl.ld_diff  = stage_valid[1] && free[2];
    ctl.ld_sum   = stage_valid[2] && free[3];
    ctl.ld_judge = stage_valid[3] && free[4];
    ctl.ld_rem   = stage_valid[4] && free[5];
    ctl.ld_quot  = stage_valid[5] && free[6];
    ld_out       = stage_valid[6] && free[7];
  end

  assign in_stall  = !free[1];
  assign out_valid = stage_valid[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (free[1]) begin
        stage_valid[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (free[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  rpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpc_front u_front (
    .clk  (clk),
    .ctl  (ctl),
    .cfg  (cfg),
    .item (item),
    .sum  (sum)
  );

  rpc_judge u_judge (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cfg (cfg),
    .sum (sum),
    .dec (dec)
  );

  rpc_scale u_scale (
    .clk  (clk),
    .ctl  (ctl),
    .sum  (sum),
    .quot (quot)
  );

  always_comb begin
    logic [31:0] delta;
    for (int i = 0; i < AXES; i++) begin
      delta = dec.neg[i] ? 32'(~quot[i] + 33'd1) : quot[i][31:0];
      case (dec.outcome) inside
        OUTCOME_LERP:                   pos_next[i] = dec.current[i] + delta;
        OUTCOME_SNAP, OUTCOME_TELEPORT: pos_next[i] = dec.target[i];
        default:                        pos_next[i] = dec.current[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      new_x            <= pos_next[0];
      new_y            <= pos_next[1];
      new_z            <= pos_next[2];
      new_yaw          <= dec.yaw;
      write_back       <= (dec.outcome != OUTCOME_SKIP);
      outcome          <= dec.outcome;
      error_l1         <= dec.err;
      worst_error_seen <= dec.worst;
      applied_total    <= dec.applied;
      lerp_total       <= dec.lerps;
      snap_total       <= dec.snaps;
    end
  end

endmodule

// ===== hdl/rpc_cfg.sv =====
module rpc_cfg
  import rpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  logic [6:0]  lerp_percent;
  logic [15:0] snap_distance_units;
  logic [7:0]  local_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lerp_percent        <= RESET_LERP_PERCENT;
      snap_distance_units <= RESET_SNAP_DIST;
      local_slot          <= RESET_LOCAL_SLOT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LERP_PERCENT: lerp_percent <= cfg_data[6:0];
        CFG_SNAP_DIST:    snap_distance_units <= cfg_data;
        CFG_LOCAL_SLOT:   local_slot <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.snap_dist  = snap_distance_units;
    cfg.local_slot = local_slot;
    if (lerp_percent < PCT_MIN) begin
      cfg.pct = PCT_MIN;
    end else if (lerp_percent > PCT_MAX) begin
      cfg.pct = PCT_MAX;
    end else begin
      cfg.pct = lerp_percent;
    end
  end

endmodule

// ===== hdl/rpc_front.sv =====
module rpc_front
  import rpc_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  cfg_t      cfg,
  input  item_t     item,
  output sum_t      sum
);

  item_t in_reg;
  diff_t diff_reg;
  diff_t diff_next;
  sum_t  sum_next;

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      in_reg <= item;
    end
  end

  always_comb begin
    logic [32:0] d;
    diff_next.elig = (in_reg.body_slot < 8'(BODY_SLOTS)) &&
                     (in_reg.body_slot != cfg.local_slot) && in_reg.body_present;
    diff_next.tele    = in_reg.teleport;
    diff_next.yaw     = in_reg.target_yaw;
    diff_next.target  = in_reg.target;
    diff_next.current = in_reg.current;
    for (int i = 0; i < AXES; i++) begin
      d = {in_reg.target[i][31], in_reg.target[i]} -
          {in_reg.current[i][31], in_reg.current[i]};
      diff_next.neg[i] = d[32];
      diff_next.mag[i] = d[32] ? 32'(~d + 33'd1) : d[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_diff) begin
      diff_reg <= diff_next;
    end
  end

  always_comb begin
    sum_next.elig    = diff_reg.elig;
    sum_next.tele    = diff_reg.tele;
    sum_next.yaw     = diff_reg.yaw;
    sum_next.target  = diff_reg.target;
    sum_next.current = diff_reg.current;
    sum_next.neg     = diff_reg.neg;
    sum_next.err     = 34'(diff_reg.mag[0]) + 34'(diff_reg.mag[1]) + 34'(diff_reg.mag[2]);
    for (int i = 0; i < AXES; i++) begin
      sum_next.prod_hi[i] = 23'(diff_reg.mag[i][31:16]) * 23'(cfg.pct);
      sum_next.prod_lo[i] = 23'(diff_reg.mag[i][15:0]) * 23'(cfg.pct);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== hdl/rpc_judge.sv =====
module rpc_judge
  import rpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pipe_ctl_t ctl,
  input  cfg_t      cfg,
  input  sum_t      sum,
  output decision_t dec
);

  logic [33:0] peak_err;
  logic [31:0] applied_counter;
  logic [31:0] lerp_counter;
  logic [31:0] snap_counter;

  logic [33:0] peak_err_next;
  logic [31:0] applied_counter_next;
  logic [31:0] lerp_counter_next;
  logic [31:0] snap_counter_next;

  decision_t dec_next;
  decision_t dec_judge;
  decision_t dec_rem;

  always_comb begin
    logic above_snap;
    above_snap = sum.err > (34'(cfg.snap_dist) << FIX_SHIFT);

    peak_err_next        = peak_err;
    applied_counter_next = applied_counter;
    lerp_counter_next    = lerp_counter;
    snap_counter_next    = snap_counter;

    dec_next.outcome = OUTCOME_SKIP;
    dec_next.yaw     = '0;
    dec_next.err     = '0;
    dec_next.target  = sum.target;
    dec_next.current = sum.current;
    dec_next.neg     = sum.neg;

    if (sum.elig) begin
      dec_next.yaw = sum.yaw;
      dec_next.err = sum.err;
      if (sum.err > peak_err) begin
        peak_err_next = sum.err;
      end
      applied_counter_next = applied_counter + 32'd1;
      if (sum.err < DEADBAND_ERR) begin
        dec_next.outcome = OUTCOME_DEADBAND;
      end else if (above_snap || sum.tele) begin
        if (sum.tele) begin
          dec_next.outcome = OUTCOME_TELEPORT;
        end else begin
          dec_next.outcome  = OUTCOME_SNAP;
          snap_counter_next = snap_counter + 32'd1;
        end
      end else begin
        dec_next.outcome  = OUTCOME_LERP;
        lerp_counter_next = lerp_counter + 32'd1;
      end
    end

    dec_next.worst   = peak_err_next;
    dec_next.applied = applied_counter_next;
    dec_next.lerps   = lerp_counter_next;
    dec_next.snaps   = snap_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_err        <= '0;
      applied_counter <= '0;
      lerp_counter    <= '0;
      snap_counter    <= '0;
    end else if (ctl.ld_judge) begin
      peak_err        <= peak_err_next;
      applied_counter <= applied_counter_next;
      lerp_counter    <= lerp_counter_next;
      snap_counter    <= snap_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_judge) begin
      dec_judge <= dec_next;
    end
    if (ctl.ld_rem) begin
      dec_rem <= dec_judge;
    end
    if (ctl.ld_quot) begin
      dec <= dec_rem;
    end
  end

  a_worst_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> peak_err >= $past(peak_err))
    else $error("Worst error register decreased.");

  a_state_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(ctl.ld_judge) |-> $stable(applied_counter) &&
      $stable(lerp_counter) && $stable(snap_counter) && $stable(peak_err))
    else $error("Correction state changed without an item entering the judge stage.");

  a_kind_implies_applied: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (lerp_counter != $past(lerp_counter) ||
      snap_counter != $past(snap_counter)) |->
      applied_counter == $past(applied_counter) + 32'd1)
    else $error("Lerp or snap counted without an applied record.");

endmodule

// ===== hdl/rpc_scale.sv =====
module rpc_scale
  import rpc_pkg::*;
(
  input  logic                   clk,
  input  pipe_ctl_t              ctl,
  input  sum_t                   sum,
  output logic [AXES-1:0][32:0]  quot
);

  logic [AXES-1:0][16:0] qa_judge;
  logic [AXES-1:0][22:0] hi_judge;
  logic [AXES-1:0][22:0] lo_judge;
  logic [AXES-1:0][16:0] qa_rem;
  logic [AXES-1:0][23:0] part_rem;
  logic [AXES-1:0][16:0] qa_quot;
  logic [AXES-1:0][16:0] qb_quot;
  logic [AXES-1:0][23:0] part_next;

  always_ff @(posedge clk) begin
    if (ctl.ld_judge) begin
      for (int i = 0; i < AXES; i++) begin
        qa_judge[i] <= div100(24'(sum.prod_hi[i]));
      end
      hi_judge <= sum.prod_hi;
      lo_judge <= sum.prod_lo;
    end
  end

  // The high half's remainder carries into the low half before the second divide.
  always_comb begin
    logic [22:0] rem;
    for (int i = 0; i < AXES; i++) begin
      rem = hi_judge[i] - 23'(qa_judge[i]) * 23'(PCT_DEN);
      part_next[i] = 24'({rem[6:0], 16'd0}) + 24'(lo_judge[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_rem) begin
      qa_rem   <= qa_judge;
      part_rem <= part_next;
    end
    if (ctl.ld_quot) begin
      qa_quot <= qa_rem;
      for (int i = 0; i < AXES; i++) begin
        qb_quot[i] <= div100(part_rem[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      quot[i] = 33'({qa_quot[i], 16'd0}) + 33'(qb_quot[i]);
    end
  end

endmodule

// ===== test/remote_position_correction_tb.sv =====
`timescale 1ns / 100ps

module remote_position_correction_tb;
  import rpc_pkg::*;

  typedef struct packed {
    logic [AXES-1:0][31:0] pos;
    logic [15:0]           yaw;
    logic                  write_back;
    outcome_t              outcome;
    logic [33:0]           err;
    logic [33:0]           worst;
    logic [31:0]           applied;
    logic [31:0]           lerps;
    logic [31:0]           snaps;
  } correction_t;

  typedef struct {
    item_t       rec;
    bit          known;
    outcome_t    want_outcome;
    logic [33:0] want_err;
  } vector_t;

  localparam longint UNIT = 4096;
  localparam longint DEADBAND = 2 * UNIT;
  localparam int RECORDS_PER_PHASE = 60;
  localparam int PHASES = 9;
  localparam int HOLD_PHASE = 4;
  localparam int PAUSE_PHASE = 5;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  body_slot = '0;
  logic        teleport = 1'b0;
  logic [15:0] target_yaw = '0;
  logic [31:0] target_x = '0;
  logic [31:0] target_y = '0;
  logic [31:0] target_z = '0;
  logic        body_present = 1'b0;
  logic [31:0] current_x = '0;
  logic [31:0] current_y = '0;
  logic [31:0] current_z = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] new_z;
  logic [15:0] new_yaw;
  logic        write_back;
  logic [2:0]  outcome;
  logic [33:0] error_l1;
  logic [33:0] worst_error_seen;
  logic [31:0] applied_total;
  logic [31:0] lerp_total;
  logic [31:0] snap_total;

  logic [6:0]  pct_q;
  logic [15:0] snap_dist_q;
  logic [7:0]  local_slot_q;
  logic [33:0] worst_q;
  logic [31:0] applied_q;
  logic [31:0] lerps_q;
  logic [31:0] snaps_q;

  correction_t expected_q [$];
  correction_t due;
  vector_t     vectors [$];
  int          mismatches = 0;
  int          settings_written = 0;
  int          outcome_seen [5] = '{0, 0, 0, 0, 0};
  bit          sender_idles = 1'b0;
  bit          receiver_idles = 1'b0;
  bit          hold_request = 1'b0;

  remote_position_correction u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .body_slot(body_slot),
    .teleport(teleport),
    .target_yaw(target_yaw),
    .target_x(target_x),
    .target_y(target_y),
    .target_z(target_z),
    .body_present(body_present),
    .current_x(current_x),
    .current_y(current_y),
    .current_z(current_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_x(new_x),
    .new_y(new_y),
    .new_z(new_z),
    .new_yaw(new_yaw),
    .write_back(write_back),
    .outcome(outcome),
    .error_l1(error_l1),
    .worst_error_seen(worst_error_seen),
    .applied_total(applied_total),
    .lerp_total(lerp_total),
    .snap_total(snap_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic correction_t predict_correction(input item_t it);
    correction_t c;
    longint cur;
    longint d;
    longint pct;
    longint err;
    c = '0;
    err = 0;
    c.pos = it.current;
    if (it.body_slot < BODY_SLOTS && it.body_slot != local_slot_q && it.body_present) begin
      for (int a = 0; a < AXES; a++) begin
        d = longint'($signed(it.target[a])) - longint'($signed(it.current[a]));
        err += (d < 0) ? -d : d;
      end
      if (err > longint'(worst_q)) worst_q = err[33:0];
      c.yaw = it.target_yaw;
      if (err < DEADBAND) begin
        c.outcome = OUTCOME_DEADBAND;
      end else if (err > longint'(snap_dist_q) * UNIT || it.teleport) begin
        c.pos = it.target;
        if (it.teleport) begin
          c.outcome = OUTCOME_TELEPORT;
        end else begin
          c.outcome = OUTCOME_SNAP;
          snaps_q++;
        end
      end else begin
        pct = (pct_q < 1) ? 1 : (pct_q > 100) ? 100 : longint'(pct_q);
        for (int a = 0; a < AXES; a++) begin
          cur = longint'($signed(it.current[a]));
          d = longint'($signed(it.target[a])) - cur;
          c.pos[a] = 32'(cur + d * pct / 100);
        end
        c.outcome = OUTCOME_LERP;
        lerps_q++;
      end
      applied_q++;
    end
    c.write_back = (c.outcome != OUTCOME_SKIP);
    c.err = err[33:0];
    c.worst = worst_q;
    c.applied = applied_q;
    c.lerps = lerps_q;
    c.snaps = snaps_q;
    return c;
  endfunction

  function automatic void add_vector(input bit known, input outcome_t want_outcome,
                                     input logic [33:0] want_err, input logic [7:0] slot,
                                     input bit tele, input logic [15:0] yaw, input bit present,
                                     input logic [31:0] tx, ty, tz, cx, cy, cz);
    vector_t v;
    v.rec.body_slot = slot;
    v.rec.teleport = tele;
    v.rec.target_yaw = yaw;
    v.rec.body_present = present;
    v.rec.target = {tz, ty, tx};
    v.rec.current = {cz, cy, cx};
    v.known = known;
    v.want_outcome = want_outcome;
    v.want_err = want_err;
    vectors.push_back(v);
  endfunction

  function automatic item_t random_record();
    item_t it;
    int span;
    it.body_slot = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(0, BODY_SLOTS - 1));
    it.teleport = ($urandom_range(0, 7) == 0);
    it.target_yaw = 16'($urandom);
    it.body_present = ($urandom_range(0, 11) != 0);
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = 2700;
      2: span = 1 << 16;
      3: span = 1 << 20;
      default: span = -1;
    endcase
    for (int a = 0; a < AXES; a++) begin
      it.current[a] = $urandom_range(0, 1) ? $urandom
                                           : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      if (span < 0) it.target[a] = $urandom;
      else it.target[a] = it.current[a] + 32'($urandom_range(0, 2 * span)) - 32'(span);
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_record(input item_t it, input bit known, input outcome_t want_outcome,
                             input logic [33:0] want_err);
    correction_t c;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    body_slot <= it.body_slot;
    teleport <= it.teleport;
    target_yaw <= it.target_yaw;
    target_x <= it.target[0];
    target_y <= it.target[1];
    target_z <= it.target[2];
    body_present <= it.body_present;
    current_x <= it.current[0];
    current_y <= it.current[1];
    current_z <= it.current[2];
    do @(posedge clk); while (in_stall);
    c = predict_correction(it);
    if (known) begin
      c.outcome = want_outcome;
      c.err = want_err;
      c.write_back = (want_outcome != OUTCOME_SKIP);
    end
    expected_q.push_back(c);
  endtask

  task automatic write_setting(input cfg_index_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LERP_PERCENT: pct_q = data[6:0];
      CFG_SNAP_DIST: snap_dist_q = data;
      CFG_LOCAL_SLOT: local_slot_q = data[7:0];
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no record outstanding");
        mismatches++;
      end else begin
        due = expected_q.pop_front();
        outcome_seen[due.outcome]++;
        check_field("new_x", due.pos[0], new_x);
        check_field("new_y", due.pos[1], new_y);
        check_field("new_z", due.pos[2], new_z);
        check_field("new_yaw", due.yaw, new_yaw);
        check_field("write_back", due.write_back, write_back);
        check_field("outcome", due.outcome, outcome);
        check_field("error_l1", due.err, error_l1);
        check_field("worst_error_seen", due.worst, worst_error_seen);
        check_field("applied_total", due.applied, applied_total);
        check_field("lerp_total", due.lerps, lerp_total);
        check_field("snap_total", due.snaps, snap_total);
      end
    end
  end

  // The long hold lets the pipeline fill so that the input side must stall.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [15:0] pct_data;
    logic [15:0] snap_data;
    logic [15:0] slot_data;
    pct_q = RESET_LERP_PERCENT;
    snap_dist_q = RESET_SNAP_DIST;
    local_slot_q = RESET_LOCAL_SLOT;
    worst_q = '0;
    applied_q = '0;
    lerps_q = '0;
    snaps_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_vector(1, OUTCOME_SKIP, 34'd0, 8'd0, 1, 16'h1234, 1,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000, 32'h80000000, 32'h80000000);
    add_vector(1, OUTCOME_SKIP, 34'd0, 8'd4, 0, 16'h0042, 1,
               32'd10000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_SKIP, 34'd0, 8'hFF, 1, 16'hFFFF, 1,
               32'hFFFFFFFF, 32'd0, 32'd5, 32'd0, 32'hFFFFFFFF, 32'd0);
    add_vector(1, OUTCOME_SKIP, 34'd0, 8'd1, 0, 16'h7FFF, 0,
               32'd900000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_DEADBAND, 34'd0, 8'd1, 0, 16'h8000, 1,
               32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_DEADBAND, 34'd8191, 8'd1, 0, 16'h0001, 1,
               32'd8191, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_LERP, 34'd8192, 8'd2, 0, 16'h00FF, 1,
               32'd4096, -32'd4096, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_DEADBAND, 34'd100, 8'd3, 1, 16'hAAAA, 1,
               32'd0, 32'd0, -32'd100, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_TELEPORT, 34'd10000, 8'd3, 1, 16'h5555, 1,
               32'd10000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_LERP, 34'd245760, 8'd1, 0, 16'h0100, 1,
               32'd0, 32'd0, 32'd0, -32'd245760, 32'd0, 32'd0);
    add_vector(1, OUTCOME_SNAP, 34'd245761, 8'd2, 0, 16'h0200, 1,
               32'd0, 32'd245761, 32'd0, 32'd0, 32'd0, 32'd0);
    add_vector(1, OUTCOME_SNAP, 34'd12884901885, 8'd3, 0, 16'h8000, 1,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000, 32'h80000000, 32'h80000000);
    add_vector(1, OUTCOME_TELEPORT, 34'd12884901885, 8'd1, 1, 16'h7FFF, 1,
               32'h80000000, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_vector(0, OUTCOME_SKIP, 34'd0, 8'd2, 0, 16'hC000, 1,
               32'd987655, 32'd1055555, 32'd999997, 32'd1000000, 32'd1000000, 32'd1000000);
    add_vector(0, OUTCOME_SKIP, 34'd0, 8'd1, 0, 16'h3FFF, 1,
               -32'd4900001, -32'd5000000, -32'd5000000,
               -32'd5000000, -32'd4990003, -32'd5000000);
    add_vector(0, OUTCOME_SKIP, 34'd0, 8'd3, 0, 16'h0FF0, 1,
               32'h7FFFF000, 32'h7FFF0000, 32'h80000000,
               32'h7FFF0000, 32'h7FFFF000, 32'h80001000);

    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    foreach (vectors[i]) begin
      send_record(vectors[i].rec, vectors[i].known, vectors[i].want_outcome,
                  vectors[i].want_err);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (p)
        0: begin
          pct_data = 16'hFF80;
          snap_data = 16'hFFFF;
          slot_data = 16'h0003;
        end
        1: begin
          pct_data = 16'h007F;
          snap_data = 16'h0000;
          slot_data = 16'hFFFF;
        end
        2: begin
          pct_data = 16'd100;
          snap_data = 16'd1;
          slot_data = 16'd1;
        end
        3: begin
          pct_data = 16'd1;
          snap_data = 16'd2;
          slot_data = 16'd0;
        end
        default: begin
          pct_data = 16'($urandom);
          snap_data = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
          slot_data = {8'($urandom), 8'($urandom_range(0, BODY_SLOTS + 1))};
        end
      endcase
      write_setting(CFG_LERP_PERCENT, pct_data);
      write_setting(CFG_SNAP_DIST, snap_data);
      write_setting(CFG_LOCAL_SLOT, slot_data);
      cfg_valid <= 1'b0;
      sender_idles = (p % 3 != 2) && (p != PHASES - 1);
      receiver_idles = sender_idles;
      if (p == HOLD_PHASE) hold_request = 1'b1;
      for (int n = 0; n < RECORDS_PER_PHASE; n++) begin
        if (p == PAUSE_PHASE && n == RECORDS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_record(random_record(), 1'b0, OUTCOME_SKIP, '0);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d skipped, %0d deadband, %0d lerp, %0d snap and %0d teleport records.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    $display("Wrote %0d register settings, lerp percent 0 and 127, snap distance 0 and 65535.",
             settings_written);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== remote_position_correction.f =====
hdl/rpc_pkg.sv
hdl/rpc_cfg.sv
hdl/rpc_front.sv
hdl/rpc_judge.sv
hdl/rpc_scale.sv
hdl/remote_position_correction.sv
test/remote_position_correction_tb.sv
